### src/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants of the sparse polynomial multiplier.
// ----------------------------------------------------------------------------
package spm_pkg;

   // Sizes
   localparam int MAX_TERMS     = 8;
   localparam int PRODUCT_SLOTS = 512;
   localparam int QUEUE_DEPTH   = 2;

   // Field widths
   localparam int ACT_W   = 2;
   localparam int COEF_W  = 16;
   localparam int EXP_W   = 8;
   localparam int PCOEF_W = 40;
   localparam int PEXP_W  = 9;
   localparam int PROD_W  = 2 * COEF_W;

   // Derived widths
   localparam int IDX_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W   = $clog2(MAX_TERMS + 1);
   localparam int SLOT_W  = $clog2(PRODUCT_SLOTS);
   localparam int SCAN_W  = SLOT_W + 1;
   localparam int ENTRY_W = PCOEF_W + 1;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 32;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD_FIRST  = 2'd0,
      ACT_LOAD_SECOND = 2'd1,
      ACT_MULTIPLY    = 2'd2,
      ACT_CLEAR       = 2'd3
   } action_type;

   typedef struct packed {
      action_type               action;
      logic signed [COEF_W-1:0] coefficient;
      logic [EXP_W-1:0]         exponent;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_MUL_RD,
      BK_MUL_WR,
      BK_SCAN,
      BK_FLUSH
   } back_state_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } back_status_type;

endpackage

### src/spm_channels.sv
// ----------------------------------------------------------------------------
// spm channels
// Valid/ready channels for request items and product results.
// ----------------------------------------------------------------------------
interface spm_req_if;
   logic                              valid;
   logic                              ready;
   logic [spm_pkg::ACT_W-1:0]         action;
   logic signed [spm_pkg::COEF_W-1:0] coefficient;
   logic [spm_pkg::EXP_W-1:0]         exponent;

   modport source (output valid, action, coefficient, exponent, input ready);
   modport sink   (input valid, action, coefficient, exponent, output ready);
endinterface

interface spm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [spm_pkg::PCOEF_W-1:0] product_coefficient;
   logic [spm_pkg::PEXP_W-1:0]         product_exponent;
   logic                               last;
   logic                               empty_res;
   logic                               overflow;

   modport source (output valid, product_coefficient, product_exponent, last,
                   empty_res, overflow, input ready);
   modport sink   (input valid, product_coefficient, product_exponent, last,
                   empty_res, overflow, output ready);
endinterface

### src/spm_ram.sv
// ----------------------------------------------------------------------------
// spm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/spm_queue.sv
// ----------------------------------------------------------------------------
// spm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module spm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  spm_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output spm_pkg::cmd_type head_cmd
);

   localparam int PTR_W = (spm_pkg::QUEUE_DEPTH > 1) ? $clog2(spm_pkg::QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(spm_pkg::QUEUE_DEPTH + 1);

   spm_pkg::cmd_type  slot_ff [spm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full       = (fill_ff == FILL_W'(spm_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(spm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(spm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/spm_front.sv
// ----------------------------------------------------------------------------
// spm_front
// Takes request transfers, decodes the action and queues the command.
// ----------------------------------------------------------------------------
module spm_front (
   spm_req_if.sink                 req,
   input  spm_pkg::back_status_type status,
   input  logic                    queue_full,
   output logic                    push,
   output spm_pkg::cmd_type        push_cmd
);

   // no transfers while the product store is being swept after reset
   assign req.ready = !queue_full && !status.clearing;
   assign push      = req.valid && req.ready;

   // decode the action code into a command
   always_comb begin
      push_cmd.coefficient = req.coefficient;
      push_cmd.exponent    = req.exponent;
      case (req.action)
         spm_pkg::ACT_LOAD_FIRST:  push_cmd.action = spm_pkg::ACT_LOAD_FIRST;
         spm_pkg::ACT_LOAD_SECOND: push_cmd.action = spm_pkg::ACT_LOAD_SECOND;
         spm_pkg::ACT_MULTIPLY:    push_cmd.action = spm_pkg::ACT_MULTIPLY;
         default:                  push_cmd.action = spm_pkg::ACT_CLEAR;
      endcase
   end

endmodule

### src/spm_back.sv
// ----------------------------------------------------------------------------
// spm_back
// Term stores, pairwise product accumulation and ordered result scan.
// ----------------------------------------------------------------------------
module spm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  spm_pkg::cmd_type         cmd,
   output logic                     cmd_pop,
   input  logic                     ascending,
   output spm_pkg::back_status_type status,
   spm_rsp_if.source                rsp
);

   localparam int MT = spm_pkg::MAX_TERMS;
   localparam int CW = spm_pkg::COEF_W;
   localparam int EW = spm_pkg::EXP_W;
   localparam int PW = spm_pkg::PCOEF_W;
   localparam int SW = spm_pkg::SLOT_W;
   localparam int NW = spm_pkg::SCAN_W;

   spm_pkg::back_state_type state_ff, state_in;

   // term stores
   logic signed [CW-1:0]        first_coef_ff [MT];
   logic signed [CW-1:0]        first_coef_in [MT];
   logic [EW-1:0]               first_exp_ff [MT];
   logic [EW-1:0]               first_exp_in [MT];
   logic signed [CW-1:0]        second_coef_ff [MT];
   logic signed [CW-1:0]        second_coef_in [MT];
   logic [EW-1:0]               second_exp_ff [MT];
   logic [EW-1:0]               second_exp_in [MT];
   logic [spm_pkg::CNT_W-1:0]   first_count_ff, first_count_in;
   logic [spm_pkg::CNT_W-1:0]   second_count_ff, second_count_in;
   logic                        ovf_ff, ovf_in;

   // sequencing
   logic [NW-1:0]               cnt_ff, cnt_in;
   logic [spm_pkg::IDX_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic signed [spm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [SW-1:0]               e_ff, e_in;
   logic                        e_ok_ff, e_ok_in;
   logic                        dv_ff, dv_in;
   logic [SW-1:0]               da_ff, da_in;
   logic                        pend_v_ff, pend_v_in;
   logic signed [PW-1:0]        pend_coef_ff, pend_coef_in;
   logic [SW-1:0]               pend_exp_ff, pend_exp_in;

   // result register
   logic                        out_valid_ff, out_valid_in;
   logic signed [PW-1:0]        out_coef_ff, out_coef_in;
   logic [spm_pkg::PEXP_W-1:0]  out_exp_ff, out_exp_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_empty_ff, out_empty_in;
   logic                        out_ovf_ff, out_ovf_in;

   // product store port
   logic                        ram_we;
   logic [SW-1:0]               ram_waddr, ram_raddr;
   logic [spm_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic                        out_free, hit, stall, scan_done, last_i, last_j;
   logic                        counts_zero, is_multiply;
   logic [EW:0]                 e_sum;
   logic [SW-1:0]               scan_slot;
   logic signed [PW-1:0]        prod_ext, rd_coef;

   spm_ram #(
      .WIDTH (spm_pkg::ENTRY_W),
      .DEPTH (spm_pkg::PRODUCT_SLOTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared decode
   assign out_free    = !out_valid_ff || rsp.ready;
   assign rd_coef     = ram_rdata[PW-1:0];
   assign hit         = dv_ff && ram_rdata[PW];
   assign stall       = hit && pend_v_ff && !out_free;
   assign scan_done   = (cnt_ff == NW'(spm_pkg::PRODUCT_SLOTS));
   assign scan_slot   = ascending ? cnt_ff[SW-1:0]
                                  : SW'(spm_pkg::PRODUCT_SLOTS - 1) - cnt_ff[SW-1:0];
   assign e_sum       = {1'b0, first_exp_ff[i_ff]} + {1'b0, second_exp_ff[j_ff]};
   assign prod_ext    = {{(PW - spm_pkg::PROD_W){prod_ff[spm_pkg::PROD_W-1]}}, prod_ff};
   assign last_i      = (spm_pkg::CNT_W'(i_ff) + 1'b1) == first_count_ff;
   assign last_j      = (spm_pkg::CNT_W'(j_ff) + 1'b1) == second_count_ff;
   assign counts_zero = (first_count_ff == '0) || (second_count_ff == '0);
   assign is_multiply = (cmd.action == spm_pkg::ACT_MULTIPLY);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spm_pkg::BK_CLEAR: begin
            if (cnt_ff == NW'(spm_pkg::PRODUCT_SLOTS - 1)) begin
               state_in = spm_pkg::BK_IDLE;
            end
         end
         spm_pkg::BK_IDLE: begin
            if (cmd_valid && is_multiply) begin
               state_in = counts_zero ? spm_pkg::BK_FLUSH : spm_pkg::BK_MUL_RD;
            end
         end
         spm_pkg::BK_MUL_RD: state_in = spm_pkg::BK_MUL_WR;
         spm_pkg::BK_MUL_WR: begin
            state_in = (last_i && last_j) ? spm_pkg::BK_SCAN : spm_pkg::BK_MUL_RD;
         end
         spm_pkg::BK_SCAN: begin
            if (!stall && scan_done) begin
               state_in = spm_pkg::BK_FLUSH;
            end
         end
         spm_pkg::BK_FLUSH: begin
            if (out_free) begin
               state_in = spm_pkg::BK_IDLE;
            end
         end
         default: state_in = spm_pkg::BK_IDLE;
      endcase
   end

   // store port and handshake outputs
   always_comb begin
      ram_we          = 1'b0;
      ram_waddr       = '0;
      ram_wdata       = '0;
      ram_raddr       = '0;
      cmd_pop         = 1'b0;
      status.clearing = 1'b0;
      status.idle     = 1'b0;
      case (state_ff)
         spm_pkg::BK_CLEAR: begin
            status.clearing = 1'b1;
            ram_we          = 1'b1;
            ram_waddr       = cnt_ff[SW-1:0];
         end
         spm_pkg::BK_IDLE: begin
            status.idle = 1'b1;
            cmd_pop     = cmd_valid;
         end
         spm_pkg::BK_MUL_RD: begin
            ram_raddr = SW'(e_sum);
         end
         spm_pkg::BK_MUL_WR: begin
            // read-modify-write of one accumulator
            ram_we    = e_ok_ff;
            ram_waddr = e_ff;
            ram_wdata = {1'b1, ram_rdata[PW] ? rd_coef + prod_ext : prod_ext};
         end
         spm_pkg::BK_SCAN: begin
            if (stall) begin
               ram_raddr = da_ff;
            end else begin
               // retire the slot just read, leaving it empty for the next run
               ram_we    = dv_ff;
               ram_waddr = da_ff;
               ram_raddr = scan_slot;
            end
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      first_coef_in   = first_coef_ff;
      first_exp_in    = first_exp_ff;
      second_coef_in  = second_coef_ff;
      second_exp_in   = second_exp_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      ovf_in          = ovf_ff;
      cnt_in          = cnt_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      prod_in         = prod_ff;
      e_in            = e_ff;
      e_ok_in         = e_ok_ff;
      dv_in           = dv_ff;
      da_in           = da_ff;
      pend_v_in       = pend_v_ff;
      pend_coef_in    = pend_coef_ff;
      pend_exp_in     = pend_exp_ff;
      out_valid_in    = out_valid_ff && !rsp.ready;
      out_coef_in     = out_coef_ff;
      out_exp_in      = out_exp_ff;
      out_last_in     = out_last_ff;
      out_empty_in    = out_empty_ff;
      out_ovf_in      = out_ovf_ff;
      case (state_ff)
         spm_pkg::BK_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
         end
         spm_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd.action)
                  spm_pkg::ACT_LOAD_FIRST: begin
                     if (first_count_ff < spm_pkg::CNT_W'(MT)) begin
                        first_coef_in[first_count_ff[spm_pkg::IDX_W-1:0]] = cmd.coefficient;
                        first_exp_in[first_count_ff[spm_pkg::IDX_W-1:0]]  = cmd.exponent;
                        first_count_in = first_count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  spm_pkg::ACT_LOAD_SECOND: begin
                     if (second_count_ff < spm_pkg::CNT_W'(MT)) begin
                        second_coef_in[second_count_ff[spm_pkg::IDX_W-1:0]] = cmd.coefficient;
                        second_exp_in[second_count_ff[spm_pkg::IDX_W-1:0]]  = cmd.exponent;
                        second_count_in = second_count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  spm_pkg::ACT_MULTIPLY: begin
                     i_in      = '0;
                     j_in      = '0;
                     pend_v_in = 1'b0;
                  end
                  default: begin
                     first_count_in  = '0;
                     second_count_in = '0;
                     ovf_in          = 1'b0;
                  end
               endcase
            end
         end
         spm_pkg::BK_MUL_RD: begin
            prod_in = first_coef_ff[i_ff] * second_coef_ff[j_ff];
            e_in    = SW'(e_sum);
            e_ok_in = {1'b0, e_sum} < (EW + 2)'(spm_pkg::PRODUCT_SLOTS);
         end
         spm_pkg::BK_MUL_WR: begin
            if (last_j) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (last_i && last_j) begin
               cnt_in = '0;
               dv_in  = 1'b0;
            end
         end
         spm_pkg::BK_SCAN: begin
            if (!stall) begin
               // a found term goes out once the next one proves it is not last
               if (hit) begin
                  if (pend_v_ff) begin
                     out_valid_in = 1'b1;
                     out_coef_in  = pend_coef_ff;
                     out_exp_in   = spm_pkg::PEXP_W'(pend_exp_ff);
                     out_last_in  = 1'b0;
                     out_empty_in = 1'b0;
                     out_ovf_in   = ovf_ff;
                  end
                  pend_v_in    = 1'b1;
                  pend_coef_in = rd_coef;
                  pend_exp_in  = da_ff;
               end
               if (scan_done) begin
                  dv_in = 1'b0;
               end else begin
                  dv_in  = 1'b1;
                  da_in  = scan_slot;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         spm_pkg::BK_FLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_coef_in  = pend_v_ff ? pend_coef_ff : '0;
               out_exp_in   = pend_v_ff ? spm_pkg::PEXP_W'(pend_exp_ff) : '0;
               out_last_in  = 1'b1;
               out_empty_in = !pend_v_ff;
               out_ovf_in   = ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= spm_pkg::BK_CLEAR;
         cnt_ff          <= '0;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         ovf_ff          <= 1'b0;
         dv_ff           <= 1'b0;
         pend_v_ff       <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         ovf_ff          <= ovf_in;
         dv_ff           <= dv_in;
         pend_v_ff       <= pend_v_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_coef_ff  <= first_coef_in;
      first_exp_ff   <= first_exp_in;
      second_coef_ff <= second_coef_in;
      second_exp_ff  <= second_exp_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      prod_ff        <= prod_in;
      e_ff           <= e_in;
      e_ok_ff        <= e_ok_in;
      da_ff          <= da_in;
      pend_coef_ff   <= pend_coef_in;
      pend_exp_ff    <= pend_exp_in;
      out_coef_ff    <= out_coef_in;
      out_exp_ff     <= out_exp_in;
      out_last_ff    <= out_last_in;
      out_empty_ff   <= out_empty_in;
      out_ovf_ff     <= out_ovf_in;
   end

   assign rsp.valid               = out_valid_ff;
   assign rsp.product_coefficient = out_coef_ff;
   assign rsp.product_exponent    = out_exp_ff;
   assign rsp.last                = out_last_ff;
   assign rsp.empty_res           = out_empty_ff;
   assign rsp.overflow            = out_ovf_ff;

endmodule

### src/sparse_polynomial_multiply.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_multiply
// Loads two sparse polynomials and emits their product term by term.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | valid/ready       | action, coefficient, exponent
//  rsp     | out       | valid/ready       | product_coefficient/_exponent,
//          |           |                   | last, empty_res, overflow
//  csr     | in        | APB write/read    | ascending_order at address 0
//
// Loads and clears finish in the back end's idle state, as they leave the queue.
// A multiply does one read-modify-write per pairwise product to accumulate, then
// an ordered scan over the product store, then a flush of the final term.
// After reset the product store is swept slot by slot; req.ready is low then.
// Results wait in an output register; a stalled rsp holds the scan in place
// once the next term is found.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiply (
   input  logic                        clock,
   input  logic                        reset,
   spm_req_if.sink                     req,
   spm_rsp_if.source                   rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [spm_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [spm_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [spm_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   logic                     asc_ff, asc_in;
   logic                     push, queue_full, cmd_valid, cmd_pop;
   spm_pkg::cmd_type         push_cmd, head_cmd;
   spm_pkg::back_status_type status;

   // one register, at address 0
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(spm_pkg::CSR_DW - 1){1'b0}}, asc_ff};

   always_comb begin
      asc_in = asc_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == '0)) begin
         asc_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asc_ff <= 1'b1;
      end else begin
         asc_ff <= asc_in;
      end
   end

   spm_front u_front (
      .req        (req),
      .status     (status),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   spm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (cmd_pop),
      .head_valid (cmd_valid),
      .head_cmd   (head_cmd)
   );

   spm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .ascending (asc_ff),
      .status    (status),
      .rsp       (rsp)
   );

endmodule

### src/spm_checker.sv
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks of the sparse polynomial multiplier.
// ----------------------------------------------------------------------------
module spm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [spm_pkg::PCOEF_W-1:0] rsp_coef,
   input logic [spm_pkg::PEXP_W-1:0]         rsp_exp,
   input logic                               rsp_last,
   input logic                               rsp_empty
);

   // reset empties the result register and starts the store sweep
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("result or request ready after reset");

   // an empty product is a single zero term marked last
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> rsp_last && rsp_coef == '0 && rsp_exp == '0)
      else $error("malformed empty result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coef) && $stable(rsp_exp))
      else $error("result changed while stalled");

endmodule

bind sparse_polynomial_multiply spm_checker u_spm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_coef  (rsp.product_coefficient),
   .rsp_exp   (rsp.product_exponent),
   .rsp_last  (rsp.last),
   .rsp_empty (rsp.empty_res)
);
